[sv/periodic_task_deadline_table_macros.svh]
// ---------------------------------------------------------------------------
// Periodic task deadline table: assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DEADLINE_TABLE_MACROS_SVH
`define PERIODIC_TASK_DEADLINE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTDT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ptdt_pkg.sv]
// ---------------------------------------------------------------------------
// Periodic task deadline table: package
// Sizes, command and status codes, and the types passed between the parts.
// ---------------------------------------------------------------------------
package ptdt_pkg;

  localparam int MAX_TASKS = 24;
  localparam int ADDR_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TOTAL_W   = $clog2(MAX_TASKS + 1);

  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 5;
  localparam int PERIOD_W = 31;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REGISTER = 2'd0,
    FUNC_TICK     = 2'd1,
    FUNC_POSTPONE = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REGISTERED = 3'd0,
    ST_FULL       = 3'd1,
    ST_POSTPONED  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FIRED      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } bk_state_t;

  typedef struct packed {
    func_t                op;
    logic [IDX_W-1:0]     idx;
    logic [PERIOD_W-1:0]  amount;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

[sv/ptdt_front.sv]
// ---------------------------------------------------------------------------
// Periodic task deadline table: front end
// Takes command items, drops unused codes and hands commands to the queue.
// ---------------------------------------------------------------------------
module ptdt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ptdt_pkg::FUNC_W-1:0]    func,
  input  logic [ptdt_pkg::IDX_W-1:0]     task_index,
  input  logic [ptdt_pkg::PERIOD_W-1:0]  interval,
  output logic                           busy,
  input  ptdt_pkg::q_flags_t             q_flags,
  output logic                           push,
  output ptdt_pkg::cmd_t                 push_cmd
);
  import ptdt_pkg::*;

  logic  hold_valid;
  cmd_t  hold_cmd;
  logic  take;

  assign busy     = hold_valid && q_flags.full;
  assign push     = hold_valid && !q_flags.full;
  assign push_cmd = hold_cmd;
  // unused code: accept and drop
  assign take     = start && !busy && (func_t'(func) != FUNC_UNUSED);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= take || (hold_valid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd.op     <= func_t'(func);
      hold_cmd.idx    <= task_index;
      hold_cmd.amount <= interval;
    end
  end

endmodule

[sv/ptdt_queue.sv]
// ---------------------------------------------------------------------------
// Periodic task deadline table: command queue
// Short FIFO between the front end and the execution unit.
// ---------------------------------------------------------------------------
module ptdt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ptdt_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output ptdt_pkg::cmd_t      head,
  output ptdt_pkg::q_flags_t  q_flags
);
  import ptdt_pkg::*;

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign q_flags.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_flags.empty = (count == '0);
  assign head          = slots[rd_ptr];
  assign do_push       = push && !q_flags.full;
  assign do_pop        = pop && !q_flags.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : Q_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= Q_CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= Q_CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[sv/ptdt_back.sv]
// ---------------------------------------------------------------------------
// Periodic task deadline table: execution unit
// Holds the clock, the task table and the tick scan; drives the results.
// ---------------------------------------------------------------------------
module ptdt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  ptdt_pkg::q_flags_t             q_flags,
  input  ptdt_pkg::cmd_t                 head,
  output logic                           pop,
  output logic                           strobe,
  output logic [ptdt_pkg::STATUS_W-1:0]  status,
  output logic [ptdt_pkg::IDX_W-1:0]     result_index,
  output logic                           last
);
  import ptdt_pkg::*;

  bk_state_t            state;
  bk_state_t            state_next;
  logic [TIME_W-1:0]    now_ms;
  logic [TOTAL_W-1:0]   task_total;
  logic [ADDR_W-1:0]    scan_idx;
  logic                 pend_valid;
  logic [ADDR_W-1:0]    pend_idx;

  logic [TIME_W-1:0]    deadline_mem [MAX_TASKS];
  logic [PERIOD_W-1:0]  period_mem   [MAX_TASKS];
  logic [TIME_W-1:0]    rd_deadline;
  logic [PERIOD_W-1:0]  rd_period;

  logic                 dl_we;
  logic                 per_we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [TIME_W-1:0]    wr_dl;
  logic [PERIOD_W-1:0]  wr_per;
  logic [ADDR_W-1:0]    rd_addr;

  logic                 strobe_next;
  status_t              status_next;
  logic [IDX_W-1:0]     result_index_next;
  logic                 last_next;

  logic                 scan_last;
  logic [TIME_W-1:0]    diff;
  logic                 overdue;
  logic                 table_full;
  logic                 idx_known;

  assign scan_last  = (TOTAL_W'(scan_idx) + 1'b1) == task_total;
  assign diff       = now_ms - rd_deadline;
  // passed: signed difference strictly positive
  assign overdue    = (diff != '0) && !diff[TIME_W-1];
  assign table_full = (task_total == TOTAL_W'(MAX_TASKS));
  assign idx_known  = (32'(head.idx) < 32'(task_total));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_flags.empty && head.op == FUNC_TICK && task_total != '0) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_last) begin
          state_next = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // table access and results
  always_comb begin
    pop               = 1'b0;
    dl_we             = 1'b0;
    per_we            = 1'b0;
    wr_addr           = '0;
    wr_dl             = '0;
    wr_per            = '0;
    rd_addr           = '0;
    strobe_next       = 1'b0;
    status_next       = ST_REGISTERED;
    result_index_next = '0;
    last_next         = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop = !q_flags.empty;
        if (!q_flags.empty) begin
          case (head.op)
            FUNC_REGISTER: begin
              strobe_next = 1'b1;
              last_next   = 1'b1;
              if (table_full) begin
                status_next = ST_FULL;
              end else begin
                dl_we             = 1'b1;
                per_we            = 1'b1;
                wr_addr           = ADDR_W'(task_total);
                wr_dl             = now_ms + TIME_W'(head.amount);
                wr_per            = head.amount;
                status_next       = ST_REGISTERED;
                result_index_next = IDX_W'(task_total);
              end
            end
            FUNC_POSTPONE: begin
              strobe_next       = 1'b1;
              last_next         = 1'b1;
              result_index_next = head.idx;
              if (idx_known) begin
                dl_we       = 1'b1;
                wr_addr     = ADDR_W'(head.idx);
                wr_dl       = now_ms + TIME_W'(head.amount);
                status_next = ST_POSTPONED;
              end else begin
                status_next = ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        rd_addr = scan_last ? scan_idx : ADDR_W'(scan_idx + 1'b1);
        if (overdue) begin
          dl_we   = 1'b1;
          wr_addr = scan_idx;
          wr_dl   = now_ms + TIME_W'(rd_period);
          // the earlier hit is now known not to be the final one
          strobe_next       = pend_valid;
          status_next       = ST_FIRED;
          result_index_next = IDX_W'(pend_idx);
        end
      end
      BK_FLUSH: begin
        strobe_next       = pend_valid;
        status_next       = ST_FIRED;
        result_index_next = IDX_W'(pend_idx);
        last_next         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      now_ms     <= '0;
      task_total <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (state == BK_IDLE) begin
        scan_idx   <= '0;
        pend_valid <= 1'b0;
        if (!q_flags.empty && head.op == FUNC_TICK) begin
          now_ms <= now_ms + 1'b1;
        end
        if (!q_flags.empty && head.op == FUNC_REGISTER && !table_full) begin
          task_total <= TOTAL_W'(task_total + 1'b1);
        end
      end else if (state == BK_SCAN) begin
        scan_idx <= ADDR_W'(scan_idx + 1'b1);
        if (overdue) begin
          pend_valid <= 1'b1;
        end
      end else begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status       <= status_next;
    result_index <= result_index_next;
    last         <= last_next;
    if (state == BK_SCAN && overdue) begin
      pend_idx <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_mem[wr_addr] <= wr_dl;
    end
    if (per_we) begin
      period_mem[wr_addr] <= wr_per;
    end
    rd_deadline <= deadline_mem[rd_addr];
    rd_period   <= period_mem[rd_addr];
  end

endmodule

[sv/periodic_task_deadline_table.sv]
// ---------------------------------------------------------------------------
// Periodic task deadline table
// Table of periodic tasks driven by register, postpone and tick commands.
// ---------------------------------------------------------------------------
// Usage:
//   Commands go in on start with func, task_index and interval; an item is
//   taken on a clock edge where start is high and busy is low. Unused func
//   codes are taken and dropped.
//   Results come out on status, result_index and last, each valid for one
//   cycle while strobe is high. The receiver cannot hold results off.
//   Register and postpone each give one result through the front register,
//   the queue and the result registers. A tick occupies the execution unit
//   for one table read per entry through a single read port, then a flush
//   state, and gives one result per fired task, the final one with last set.
//   A two-entry queue sits between the front end and the execution unit, so
//   up to three items may be taken while a tick is being worked through;
//   busy rises when the queue and the front register are both full.
//   Reset clears the clock, the task count and all control state; table
//   entries are written before they are read and need no clearing.
// ---------------------------------------------------------------------------
`include "periodic_task_deadline_table_macros.svh"

module periodic_task_deadline_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ptdt_pkg::FUNC_W-1:0]    func,
  input  logic [ptdt_pkg::IDX_W-1:0]     task_index,
  input  logic [ptdt_pkg::PERIOD_W-1:0]  interval,
  output logic                           strobe,
  output logic [ptdt_pkg::STATUS_W-1:0]  status,
  output logic [ptdt_pkg::IDX_W-1:0]     result_index,
  output logic                           last
);
  import ptdt_pkg::*;

  q_flags_t q_flags;
  logic     push;
  cmd_t     push_cmd;
  logic     pop;
  cmd_t     head;

  ptdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .task_index (task_index),
    .interval   (interval),
    .busy       (busy),
    .q_flags    (q_flags),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ptdt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_flags  (q_flags)
  );

  ptdt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_flags      (q_flags),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .status       (status),
    .result_index (result_index),
    .last         (last)
  );

  `PTDT_ASSERT_SAME(a_lone_last, strobe && (status != ST_FIRED), last, "lone result without last")
  `PTDT_ASSERT_SAME(a_busy_only_when_full, busy, q_flags.full, "busy while queue has room")
  `PTDT_ASSERT_SAME(a_no_pop_when_empty, pop && q_flags.empty, 1'b0, "pop from empty queue")

endmodule
